// File: hw/rtl/sprite_list_visibility_scan_defines.svh
// assertion macros used by the sprite list scan back part
`ifndef SPRITE_LIST_VISIBILITY_SCAN_DEFINES_SVH
`define SPRITE_LIST_VISIBILITY_SCAN_DEFINES_SVH

// property must hold at every rising clock edge outside reset
`define SLS_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// condition must never be seen outside reset
`define SLS_ASSERT_NEVER(name, clk, rst, cond, msg) \
   name: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// File: hw/rtl/sls_pkg.sv
// types, constants and register codes for the sprite list scan
`default_nettype none

package sls_pkg;

   localparam int MAX_ENTRIES_DEFAULT = 80;
   localparam int QUEUE_DEPTH         = 2;

   // register reset values
   localparam logic [6:0] RESET_TABLE_BASE    = 7'd0;
   localparam logic [8:0] RESET_VISIBLE_WIDTH = 9'd264;
   localparam logic [8:0] RESET_TOP_LINE      = 9'd0;
   localparam logic [8:0] RESET_BOTTOM_LINE   = 9'd224;

   // horizontal range: x field above this and below width plus offset
   localparam logic [8:0] X_LOW_LIMIT = 9'd96;
   localparam logic [9:0] X_OFFSET    = 10'd120;
   localparam logic signed [10:0] Y_OFFSET = 11'sd128;

   localparam logic [6:0] COUNT_SAT = 7'd127;

   typedef enum logic [2:0] {
      CSR_TABLE_BASE      = 3'd0,
      CSR_WIDE_MODE       = 3'd1,
      CSR_WANTED_PRIORITY = 3'd2,
      CSR_VISIBLE_WIDTH   = 3'd3,
      CSR_TOP_LINE        = 3'd4,
      CSR_BOTTOM_LINE     = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [6:0] sprite_table_base;
      logic       wide_mode;
      logic       wanted_priority;
      logic [8:0] visible_width;
      logic [8:0] top_line;
      logic [8:0] bottom_line;
   } cfg_type;

   typedef struct packed {
      logic        frame_start;
      logic [15:0] y_word;
      logic [15:0] size_link_word;
      logic [15:0] attr_word;
      logic [15:0] x_word;
   } req_type;

   // classified entry between front and back
   typedef struct packed {
      logic               frame_start;
      logic signed [10:0] span_top;
      logic signed [10:0] span_bottom;
      logic               mask_sprite;
      logic               draw_ok;
      logic [6:0]         link;
   } entry_type;

   typedef struct packed {
      logic [6:0]  entry_index;
      logic        selected;
      logic [6:0]  next_index;
      logic [14:0] next_fetch_address;
      logic [6:0]  selected_count;
      logic        last;
   } rsp_type;

endpackage

`default_nettype wire

// File: hw/rtl/sls_fifo.sv
// small register queue used between the pipeline parts
`default_nettype none

module sls_fifo #(
   parameter int DEPTH = sls_pkg::QUEUE_DEPTH,
   parameter int WIDTH = 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] wdata,
   output      logic             full,
   input  wire logic             pop,
   output      logic [WIDTH-1:0] rdata,
   output      logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNT_FULL);
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = mem_ff[rd_ptr_ff];

   // pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

`default_nettype wire

// File: hw/rtl/sls_front.sv
// front part: decodes one table entry into line span and draw checks
`default_nettype none

module sls_front (
   input  wire sls_pkg::req_type   req,
   input  wire sls_pkg::cfg_type   cfg,
   output      sls_pkg::entry_type entry
);

   logic [8:0]  y_field;
   logic [8:0]  x_field;
   logic [1:0]  cells;
   logic [5:0]  height;
   logic        prio_ok;
   logic        x_ok;

   // vertical span of the sprite in lines
   assign y_field = req.y_word[8:0];
   assign cells   = req.size_link_word[9:8];
   assign height  = 6'(({4'b0, cells} + 6'd1) << 3);

   // horizontal range and priority
   assign x_field = req.x_word[8:0];
   assign prio_ok = (req.attr_word[15] == cfg.wanted_priority);
   assign x_ok    = (x_field > sls_pkg::X_LOW_LIMIT) &&
                    ({1'b0, x_field} < ({1'b0, cfg.visible_width} + sls_pkg::X_OFFSET));

   always_comb begin
      entry.frame_start = req.frame_start;
      entry.span_top    = $signed({2'b00, y_field}) - sls_pkg::Y_OFFSET;
      entry.span_bottom = entry.span_top + $signed({5'b0, height});
      entry.mask_sprite = (x_field == 9'd0);
      entry.draw_ok     = prio_ok && x_ok;
      entry.link        = req.size_link_word[6:0];
   end

endmodule

`default_nettype wire

// File: hw/rtl/sls_back.sv
// back part: line window, mask merging, counters and fetch address
`default_nettype none

`include "sprite_list_visibility_scan_defines.svh"

module sls_back #(
   parameter int MAX_ENTRIES = sls_pkg::MAX_ENTRIES_DEFAULT
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire sls_pkg::cfg_type   cfg,
   input  wire logic               in_valid,
   input  wire sls_pkg::entry_type in_entry,
   output      logic               in_take,
   input  wire logic               out_full,
   output      logic               out_push,
   output      sls_pkg::rsp_type   out_rsp
);

   localparam logic [6:0] LAST_COUNT = 7'(MAX_ENTRIES);

   logic [6:0]         current_index_ff, current_index_in;
   logic signed [10:0] window_top_ff, window_top_in;
   logic signed [10:0] window_bottom_ff, window_bottom_in;
   logic               mask_pending_ff, mask_pending_in;
   logic signed [10:0] mask_from_ff, mask_from_in;
   logic signed [10:0] mask_to_ff, mask_to_in;
   logic [6:0]         entries_seen_ff, entries_seen_in;
   logic [6:0]         chosen_count_ff, chosen_count_in;

   // state as seen by this entry, after a frame restart
   logic [6:0]         cur_index;
   logic signed [11:0] cur_top, cur_bottom, cur_from, cur_to;
   logic               cur_pending;
   logic [6:0]         cur_seen, cur_chosen;
   logic signed [11:0] sy, ey, ns, ne;
   logic               visible, sel;
   logic [6:0]         table_bits;

   assign in_take  = in_valid && !out_full;
   assign out_push = in_take;

   // frame restart
   always_comb begin
      if (in_entry.frame_start) begin
         cur_index   = '0;
         cur_top     = $signed({3'b000, cfg.top_line});
         cur_bottom  = $signed({3'b000, cfg.bottom_line});
         cur_pending = 1'b0;
         cur_from    = '0;
         cur_to      = '0;
         cur_seen    = '0;
         cur_chosen  = '0;
      end else begin
         cur_index   = current_index_ff;
         cur_top     = {window_top_ff[10], window_top_ff};
         cur_bottom  = {window_bottom_ff[10], window_bottom_ff};
         cur_pending = mask_pending_ff;
         cur_from    = {mask_from_ff[10], mask_from_ff};
         cur_to      = {mask_to_ff[10], mask_to_ff};
         cur_seen    = entries_seen_ff;
         cur_chosen  = chosen_count_ff;
      end
   end

   // window test, mask merge and selection
   always_comb begin
      sy      = {in_entry.span_top[10], in_entry.span_top};
      ey      = {in_entry.span_bottom[10], in_entry.span_bottom};
      visible = !((ey <= cur_top) || (sy > cur_bottom));
      ns      = sy;
      ne      = ey;
      if (cur_pending) begin
         if ((cur_to + 12'sd1 >= sy) && (cur_to <= ey) && (cur_from < sy)) begin
            ns = cur_from;
         end else if ((cur_from - 12'sd1 <= ey) && (cur_from >= sy) && (cur_to > ey)) begin
            ne = cur_to;
         end
      end
      window_top_in    = cur_top[10:0];
      window_bottom_in = cur_bottom[10:0];
      mask_pending_in  = cur_pending;
      mask_from_in     = cur_from[10:0];
      mask_to_in       = cur_to[10:0];
      sel              = 1'b0;
      if (visible) begin
         if (in_entry.mask_sprite) begin
            if ((ns <= cur_top) && (ne + 12'sd1 > cur_top)) begin
               window_top_in = 11'(ne + 12'sd1);
            end else if ((ne >= cur_bottom) && (ns - 12'sd1 < cur_bottom)) begin
               window_bottom_in = 11'(ns - 12'sd1);
            end else begin
               mask_pending_in = 1'b1;
               mask_from_in    = ns[10:0];
               mask_to_in      = ne[10:0];
            end
         end else begin
            sel = in_entry.draw_ok;
         end
      end
   end

   // counters and result
   always_comb begin
      chosen_count_in  = (sel && cur_chosen < sls_pkg::COUNT_SAT) ?
                         cur_chosen + 7'd1 : cur_chosen;
      entries_seen_in  = (cur_seen < sls_pkg::COUNT_SAT) ? cur_seen + 7'd1 : cur_seen;
      current_index_in = in_entry.link;
      table_bits       = cfg.wide_mode ? {cfg.sprite_table_base[6:1], 1'b0} :
                                         cfg.sprite_table_base;

      out_rsp.entry_index        = cur_index;
      out_rsp.selected           = sel;
      out_rsp.next_index         = in_entry.link;
      out_rsp.next_fetch_address = {table_bits, 8'h00} + {6'b0, in_entry.link, 2'b00};
      out_rsp.selected_count     = chosen_count_in;
      out_rsp.last               = (in_entry.link == 7'd0) || (entries_seen_in >= LAST_COUNT);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         current_index_ff <= '0;
         window_top_ff    <= $signed({2'b00, sls_pkg::RESET_TOP_LINE});
         window_bottom_ff <= $signed({2'b00, sls_pkg::RESET_BOTTOM_LINE});
         mask_pending_ff  <= 1'b0;
         mask_from_ff     <= '0;
         mask_to_ff       <= '0;
         entries_seen_ff  <= '0;
         chosen_count_ff  <= '0;
      end else if (in_take) begin
         current_index_ff <= current_index_in;
         window_top_ff    <= window_top_in;
         window_bottom_ff <= window_bottom_in;
         mask_pending_ff  <= mask_pending_in;
         mask_from_ff     <= mask_from_in;
         mask_to_ff       <= mask_to_in;
         entries_seen_ff  <= entries_seen_in;
         chosen_count_ff  <= chosen_count_in;
      end
   end

   // checks
   `SLS_ASSERT(a_chosen_le_seen, clock, reset, chosen_count_ff <= entries_seen_ff, "selected count ran ahead of entries seen")
   `SLS_ASSERT(a_frame_restart, clock, reset, (in_take && in_entry.frame_start) |=> (entries_seen_ff == 7'd1 && chosen_count_ff <= 7'd1), "frame start did not restart counters")
   `SLS_ASSERT(a_mask_clear_on_frame, clock, reset, $fell(mask_pending_ff) |-> $past(in_take && in_entry.frame_start), "pending mask dropped without frame start")
   `SLS_ASSERT_NEVER(a_push_without_take, clock, reset, out_push && !in_valid, "result pushed with no entry")

endmodule

`default_nettype wire

// File: hw/rtl/sprite_list_visibility_scan.sv
// top level of the sprite list scan: registers, queues, front and back
//
// Usage:
//   req_ channel: push one sprite table entry (four words plus frame_start)
//   when req_full is low. Set frame_start on the first entry of each frame.
//   rsp_ channel: while rsp_empty is low, rsp_data holds the oldest result
//   (selected flag, next link, next fetch address, count, last); pop takes it.
//   csr_ channel: csr_ready is always high; csr_index picks the register,
//   csr_data the value (indexes past the list are ignored). Write only while
//   no entry is in flight.
// Path: entry queue, back part, result queue. Throughput: one entry per cycle
//   while the result queue has room; the back part updates the line window and
//   mask range once per entry, so that loop sets the rate.
// Reset: registers return to their defaults, the window to lines 0..224 and
//   both queues empty.
// When the consumer stops popping, the result queue fills, the back part
//   halts, the entry queue fills and req_full rises; nothing is dropped.
`default_nettype none

module sprite_list_visibility_scan #(
   parameter int MAX_ENTRIES = sls_pkg::MAX_ENTRIES_DEFAULT
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_push,
   output      logic             req_full,
   input  wire sls_pkg::req_type req_data,
   output      logic             rsp_empty,
   input  wire logic             rsp_pop,
   output      sls_pkg::rsp_type rsp_data,
   input  wire logic             csr_valid,
   output      logic             csr_ready,
   input  wire logic [2:0]       csr_index,
   input  wire logic [8:0]       csr_data
);

   localparam int ENTRY_W = $bits(sls_pkg::entry_type);
   localparam int RSP_W   = $bits(sls_pkg::rsp_type);

   sls_pkg::cfg_type   cfg_ff, cfg_in;
   sls_pkg::entry_type front_entry, back_entry;
   sls_pkg::rsp_type   back_rsp;
   logic               mid_full, mid_empty, back_take;
   logic               rsp_full, back_push;

   // configuration registers
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (sls_pkg::csr_index_type'(csr_index))
            sls_pkg::CSR_TABLE_BASE:      cfg_in.sprite_table_base = csr_data[6:0];
            sls_pkg::CSR_WIDE_MODE:       cfg_in.wide_mode         = csr_data[0];
            sls_pkg::CSR_WANTED_PRIORITY: cfg_in.wanted_priority   = csr_data[0];
            sls_pkg::CSR_VISIBLE_WIDTH:   cfg_in.visible_width     = csr_data;
            sls_pkg::CSR_TOP_LINE:        cfg_in.top_line          = csr_data;
            sls_pkg::CSR_BOTTOM_LINE:     cfg_in.bottom_line       = csr_data;
            default:                      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sprite_table_base <= sls_pkg::RESET_TABLE_BASE;
         cfg_ff.wide_mode         <= 1'b0;
         cfg_ff.wanted_priority   <= 1'b0;
         cfg_ff.visible_width     <= sls_pkg::RESET_VISIBLE_WIDTH;
         cfg_ff.top_line          <= sls_pkg::RESET_TOP_LINE;
         cfg_ff.bottom_line       <= sls_pkg::RESET_BOTTOM_LINE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // entry decode
   sls_front u_front (
      .req   (req_data),
      .cfg   (cfg_ff),
      .entry (front_entry)
   );

   assign req_full = mid_full;

   // queue between front and back
   sls_fifo #(
      .DEPTH (sls_pkg::QUEUE_DEPTH),
      .WIDTH (ENTRY_W)
   ) u_mid_queue (
      .clock (clock),
      .reset (reset),
      .push  (req_push),
      .wdata (front_entry),
      .full  (mid_full),
      .pop   (back_take),
      .rdata (back_entry),
      .empty (mid_empty)
   );

   // scan state and result
   sls_back #(
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .in_valid (!mid_empty),
      .in_entry (back_entry),
      .in_take  (back_take),
      .out_full (rsp_full),
      .out_push (back_push),
      .out_rsp  (back_rsp)
   );

   // result queue
   sls_fifo #(
      .DEPTH (sls_pkg::QUEUE_DEPTH),
      .WIDTH (RSP_W)
   ) u_rsp_queue (
      .clock (clock),
      .reset (reset),
      .push  (back_push),
      .wdata (back_rsp),
      .full  (rsp_full),
      .pop   (rsp_pop),
      .rdata (rsp_data),
      .empty (rsp_empty)
   );

endmodule

`default_nettype wire

// File: dv/sls_scan_checker.sv
// checker for the sprite list scan: watches the channels, predicts each result and compares
`timescale 1ns / 1ps

module sls_scan_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   input  logic             req_full,
   input  sls_pkg::req_type req_data,
   input  logic             rsp_empty,
   input  logic             rsp_pop,
   input  sls_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   input  logic             csr_ready,
   input  logic [2:0]       csr_index,
   input  logic [8:0]       csr_data,
   output int               error_count,
   output int               outstanding
);
   import sls_pkg::*;

   localparam int ENTRY_LIMIT = MAX_ENTRIES_DEFAULT;
   localparam int SAT_COUNT   = 127;

   // register copies
   logic [6:0] reg_base;
   logic       reg_wide;
   logic       reg_prio;
   logic [8:0] reg_width;
   logic [8:0] reg_top;
   logic [8:0] reg_bottom;

   // scan state, lines are signed
   logic [6:0] cur_link;
   int         line_top;
   int         line_bottom;
   bit         mask_armed;
   int         mask_lo;
   int         mask_hi;
   int         seen_count;
   int         pick_count;

   rsp_type    pending_results[$];
   rsp_type    oldest;

   // start of a frame: window back to the registers, counts cleared
   function automatic void clear_scan();
      cur_link    = '0;
      line_top    = reg_top;
      line_bottom = reg_bottom;
      mask_armed  = 1'b0;
      mask_lo     = 0;
      mask_hi     = 0;
      seen_count  = 0;
      pick_count  = 0;
   endfunction

   function automatic void write_register(logic [2:0] idx, logic [8:0] value);
      case (csr_index_type'(idx))
         CSR_TABLE_BASE:      reg_base   = value[6:0];
         CSR_WIDE_MODE:       reg_wide   = value[0];
         CSR_WANTED_PRIORITY: reg_prio   = value[0];
         CSR_VISIBLE_WIDTH:   reg_width  = value;
         CSR_TOP_LINE:        reg_top    = value;
         CSR_BOTTOM_LINE:     reg_bottom = value;
         default: ;
      endcase
   endfunction

   // one table entry in, one scan result out
   function automatic rsp_type scan_entry(req_type e);
      rsp_type    r;
      int         sy;
      int         span_end;
      int         height;
      int         xfield;
      int         sx;
      int         lim;
      int         addr;
      logic [6:0] link;
      logic [6:0] tbase;
      bit         sel;
      sel = 1'b0;
      if (e.frame_start)
         clear_scan();
      sy       = e.y_word[8:0];
      sy       = sy - 128;
      height   = e.size_link_word[9:8];
      height   = (height + 1) * 8;
      span_end = sy + height;
      xfield   = e.x_word[8:0];
      lim      = reg_width;

      // vertical window test, then masking or selection
      if (!(span_end <= line_top || sy > line_bottom)) begin
         if (xfield == 0) begin
            // merge with the pending mask range where they touch
            if (mask_armed) begin
               if (mask_hi + 1 >= sy && mask_hi <= span_end && mask_lo < sy)
                  sy = mask_lo;
               else if (mask_lo - 1 <= span_end && mask_lo >= sy && mask_hi > span_end)
                  span_end = mask_hi;
            end
            if (sy <= line_top && span_end + 1 > line_top) begin
               line_top = span_end + 1;
            end else if (span_end >= line_bottom && sy - 1 < line_bottom) begin
               line_bottom = sy - 1;
            end else begin
               mask_armed = 1'b1;
               mask_lo    = sy;
               mask_hi    = span_end;
            end
         end else if (e.attr_word[15] == reg_prio) begin
            sx = xfield - 120;
            if (!(sx <= -24 || sx >= lim))
               sel = 1'b1;
         end
      end

      if (sel && pick_count < SAT_COUNT)
         pick_count++;
      if (seen_count < SAT_COUNT)
         seen_count++;

      link  = e.size_link_word[6:0];
      tbase = reg_base & (reg_wide ? 7'h7e : 7'h7f);
      addr  = (int'(tbase) << 8) + (int'(link) << 2);

      r.entry_index        = cur_link;
      r.selected           = sel;
      r.next_index         = link;
      r.next_fetch_address = 15'(addr & 32'h7ffc);
      r.selected_count     = 7'(pick_count);
      r.last               = (link == 7'd0) || (seen_count >= ENTRY_LIMIT);
      cur_link = link;
      return r;
   endfunction

   function automatic void check_field(string label, int want, int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d actual %0d", $time, label, want, got);
         error_count++;
      end
   endfunction

   // watch all three channels
   always @(posedge clock) begin
      if (reset) begin
         reg_base   = RESET_TABLE_BASE;
         reg_wide   = 1'b0;
         reg_prio   = 1'b0;
         reg_width  = RESET_VISIBLE_WIDTH;
         reg_top    = RESET_TOP_LINE;
         reg_bottom = RESET_BOTTOM_LINE;
         clear_scan();
         pending_results.delete();
         outstanding <= 0;
      end else begin
         if (csr_valid && csr_ready)
            write_register(csr_index, csr_data);
         if (req_push && !req_full)
            pending_results.push_back(scan_entry(req_data));
         if (rsp_pop && !rsp_empty) begin
            if (pending_results.size() == 0) begin
               $display("%0t: result transaction with none expected, actual %h",
                        $time, rsp_data);
               error_count++;
            end else begin
               oldest = pending_results.pop_front();
               check_field("entry_index", oldest.entry_index, rsp_data.entry_index);
               check_field("selected", oldest.selected, rsp_data.selected);
               check_field("next_index", oldest.next_index, rsp_data.next_index);
               check_field("next_fetch_address", oldest.next_fetch_address,
                           rsp_data.next_fetch_address);
               check_field("selected_count", oldest.selected_count,
                           rsp_data.selected_count);
               check_field("last", oldest.last, rsp_data.last);
            end
         end
         outstanding <= pending_results.size();
      end
   end

endmodule

// File: dv/tb_sprite_list_visibility_scan.sv
// testbench top for the sprite list scan: stimulus, idling, timeout and verdict
`timescale 1ns / 1ps

module tb_sprite_list_visibility_scan;
   import sls_pkg::*;

   localparam int         CYCLE_LIMIT = 600000;
   localparam int         HOLD_AFTER  = 300;
   localparam int         HOLD_CYCLES = 200;
   localparam logic [2:0] CSR_SPARE_A = 3'd6;
   localparam logic [2:0] CSR_SPARE_B = 3'd7;

   logic       clock     = 1'b0;
   logic       reset     = 1'b1;
   logic       req_push  = 1'b0;
   logic       req_full;
   req_type    req_data  = '0;
   logic       rsp_empty;
   logic       rsp_pop   = 1'b0;
   rsp_type    rsp_data;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic [2:0] csr_index = '0;
   logic [8:0] csr_data  = '0;

   int error_count;
   int outstanding;
   int cycle_count = 0;
   bit burst_mode  = 1'b0;

   // register values as last written, used to aim the stimulus
   logic stim_prio   = 1'b0;
   int   stim_width  = RESET_VISIBLE_WIDTH;
   int   stim_top    = RESET_TOP_LINE;
   int   stim_bottom = RESET_BOTTOM_LINE;

   sprite_list_visibility_scan u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   sls_scan_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_full    (req_full),
      .req_data    (req_data),
      .rsp_empty   (rsp_empty),
      .rsp_pop     (rsp_pop),
      .rsp_data    (rsp_data),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .error_count (error_count),
      .outstanding (outstanding)
   );

   // clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // mostly short gaps, a few long ones, none in burst phases
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (burst_mode || r < 50)
         return 0;
      else if (r < 85)
         return $urandom_range(1, 3);
      else if (r < 97)
         return $urandom_range(4, 10);
      else
         return $urandom_range(20, 60);
   endfunction

   // one entry with random content, aimed at the current window and range
   function automatic req_type make_entry(bit fs, logic [6:0] link);
      req_type e;
      int      r;
      int      lo;
      int      hi;
      int      xf;
      e.frame_start    = fs;
      e.y_word         = 16'($urandom);
      e.size_link_word = 16'($urandom);
      e.attr_word      = 16'($urandom);
      e.x_word         = 16'($urandom);
      e.size_link_word[6:0] = link;
      r = $urandom_range(0, 99);
      // noise entry: all words random but the link field
      if (r < 10)
         return e;
      lo = stim_top + 88;
      hi = stim_bottom + 136;
      if (lo < 0)
         lo = 0;
      if (hi > 511)
         hi = 511;
      if (lo > hi) begin
         lo = 0;
         hi = 511;
      end
      e.y_word[8:0] = 9'($urandom_range(hi, lo));
      if (r < 35) begin
         e.x_word[8:0] = '0;
      end else begin
         case ($urandom_range(0, 3))
            0: xf = $urandom_range(96, 98);
            1: begin
               xf = $urandom_range(0, 2);
               xf = stim_width + 119 + xf;
            end
            default: xf = $urandom_range(1, 511);
         endcase
         if (xf < 1)
            xf = 1;
         if (xf > 511)
            xf = 511;
         e.x_word[8:0] = 9'(xf);
      end
      e.attr_word[15] = ($urandom_range(0, 3) != 0) ? stim_prio : ~stim_prio;
      return e;
   endfunction

   // offer one entry after a random gap, return once it is accepted
   task automatic send_entry(req_type e);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push <= 1'b1;
      req_data <= e;
      do @(posedge clock); while (req_full);
   endtask

   task automatic send_words(bit fs, logic [15:0] y, logic [15:0] sl, logic [15:0] a,
                             logic [15:0] x);
      req_type e;
      e = '{fs, y, sl, a, x};
      send_entry(e);
   endtask

   // linked frames of random length, some too long, some without frame_start
   task automatic run_phase(int items);
      int count;
      int len;
      int i;
      bit fs;
      logic [6:0] link;
      count = 0;
      burst_mode = ($urandom_range(0, 3) == 0);
      while (count < items) begin
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(70, 100) : $urandom_range(1, 30);
         for (i = 0; i < len; i++) begin
            link = (i == len - 1) ? 7'd0 : 7'($urandom_range(1, 127));
            fs   = (i == 0) && ($urandom_range(0, 9) != 0);
            send_entry(make_entry(fs, link));
         end
         count += len;
      end
      burst_mode = 1'b0;
   endtask

   // stop offering and let every result drain
   task automatic wait_idle();
      req_push <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // leaves csr_valid high so that back-to-back writes need no extra edge
   task automatic write_csr(logic [2:0] idx, logic [8:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic apply_cfg(logic [6:0] base, logic wide, logic prio, logic [8:0] width,
                            logic [8:0] top, logic [8:0] bottom);
      write_csr(CSR_TABLE_BASE, {2'b00, base});
      write_csr(CSR_WIDE_MODE, {8'h00, wide});
      write_csr(CSR_WANTED_PRIORITY, {8'h00, prio});
      write_csr(CSR_VISIBLE_WIDTH, width);
      write_csr(CSR_TOP_LINE, top);
      write_csr(CSR_BOTTOM_LINE, bottom);
      csr_valid   <= 1'b0;
      stim_prio   = prio;
      stim_width  = width;
      stim_top    = top;
      stim_bottom = bottom;
   endtask

   // result side: random pops, one long hold-off to back the block up
   initial begin : drain_results
      int taken;
      int gap;
      taken = 0;
      @(posedge clock);
      forever begin
         gap = pick_gap();
         if (gap > 0) begin
            rsp_pop <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         if (taken == HOLD_AFTER) begin
            rsp_pop <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_pop <= 1'b1;
         do @(posedge clock); while (rsp_empty);
         taken++;
      end
   end

   // main stimulus
   initial begin : stimulus
      int         p;
      int         i;
      req_type    e;
      logic [8:0] width;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed entries at reset settings: window 0..224, width 264, priority 0
      send_words(1'b1, 16'h0000, 16'h0001, 16'h0000, 16'h0000); // mask above window, ignored
      send_words(1'b0, 16'hffff, 16'hffff, 16'hffff, 16'hffff); // below window
      send_words(1'b0, 16'h0090, 16'h0302, 16'h0000, 16'h0060); // left edge, dropped
      send_words(1'b0, 16'h0090, 16'h0303, 16'h0000, 16'h0061); // first column in range
      send_words(1'b0, 16'h0090, 16'h0104, 16'h0000, 16'h017f); // last column in range
      send_words(1'b0, 16'h0090, 16'h0205, 16'h0000, 16'h0180); // right edge, dropped
      send_words(1'b0, 16'h0090, 16'h0006, 16'h8000, 16'h0100); // wrong priority
      send_words(1'b0, 16'h0078, 16'h0007, 16'h1234, 16'h0000); // mask ends on top line, ignored
      send_words(1'b0, 16'h015c, 16'h0008, 16'h0000, 16'h0000); // mask lowers bottom
      send_words(1'b0, 16'h00e4, 16'h0009, 16'h0000, 16'h0000); // mask left pending
      send_words(1'b0, 16'h00e9, 16'h000a, 16'h0000, 16'h0000); // merge from below
      send_words(1'b0, 16'h00dc, 16'h000b, 16'h0000, 16'h0000); // merge from above
      send_words(1'b0, 16'h00b2, 16'h000c, 16'h0000, 16'h0000); // mask with no overlap
      send_words(1'b0, 16'hfea8, 16'h000d, 16'h7fff, 16'hfe00); // mask, high bits set
      send_words(1'b0, 16'h0080, 16'h000e, 16'h0000, 16'h0100); // visible, selected
      send_words(1'b0, 16'h0079, 16'h000f, 16'h0000, 16'h0100); // ends one line below top, selected
      send_words(1'b0, 16'h015b, 16'h0010, 16'h0000, 16'h0100); // on lowered bottom
      send_words(1'b0, 16'h015c, 16'h0011, 16'h0000, 16'h0100); // just past bottom
      send_words(1'b0, 16'h0090, 16'h0000, 16'h0000, 16'h0100); // link zero
      send_words(1'b0, 16'h0090, 16'h0205, 16'h0000, 16'h0100); // after last, no restart
      send_words(1'b1, 16'h0080, 16'h0000, 16'h0000, 16'h0100); // new frame, window reset
      wait_idle();

      // full window, widest range, long frame saturates both counts
      apply_cfg(7'd127, 1'b0, 1'b1, 9'd511, 9'd0, 9'd511);
      for (i = 0; i < 140; i++) begin
         e = make_entry(i == 0, 7'($urandom_range(1, 127)));
         e.y_word[8:0]  = 9'h100;
         e.x_word[8:0]  = 9'h100;
         e.attr_word[15] = stim_prio;
         send_entry(e);
      end
      run_phase(100);
      wait_idle();

      // empty window and zero width, wide mode
      apply_cfg(7'd127, 1'b1, 1'b0, 9'd0, 9'd511, 9'd0);
      run_phase(100);
      wait_idle();

      // writes past the register list, then a middle setting
      write_csr(CSR_SPARE_A, 9'($urandom));
      write_csr(CSR_SPARE_B, 9'($urandom));
      apply_cfg(7'h55, 1'b1, 1'b1, 9'd320, 9'd16, 9'd200);
      run_phase(130);
      wait_idle();

      // random settings
      for (p = 0; p < 5; p++) begin
         width = ($urandom_range(0, 3) == 0) ? 9'($urandom_range(0, 511))
                                             : 9'($urandom_range(200, 511));
         apply_cfg(7'($urandom_range(0, 127)), 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)), width, 9'($urandom_range(0, 100)),
                   9'($urandom_range(150, 511)));
         run_phase(120);
         wait_idle();
      end

      if (error_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

// File: sprite_list_visibility_scan.f
+incdir+hw/rtl
hw/rtl/sls_pkg.sv
hw/rtl/sls_fifo.sv
hw/rtl/sls_front.sv
hw/rtl/sls_back.sv
hw/rtl/sprite_list_visibility_scan.sv
dv/sls_scan_checker.sv
dv/tb_sprite_list_visibility_scan.sv
